>>> rtl/htlp_pkg.sv
// shared types and constants of the linear-probing hash table
// no dependencies; every other rtl file refers to it by scoped names
`timescale 1ns / 1ps

package htlp_pkg;

  // default geometry of the table
  localparam int TableDepthDef = 256;
  localparam int KeyWidthDef   = 32;
  localparam int ValueWidthDef = 32;

  // fixed widths of the port fields
  localparam int FieldW = 32;
  localparam int HomeW  = 8;

  // entries of the command queue between front and back
  localparam int CmdQueueDepth = 2;

  // command codes as they arrive on the func field
  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncLookup = 2'd1;
  localparam logic [1:0] FuncErase  = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_ERASE,
    OP_NOP
  } op_e;

  // probe engine states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_PROBE
  } eng_state_e;

  // one input transfer
  typedef struct packed {
    logic [1:0]        func;
    logic [FieldW-1:0] key;
    logic [FieldW-1:0] value;
    logic [HomeW-1:0]  home_slot;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic              ok;
    logic [FieldW-1:0] found_value;
  } result_t;

  // classified command held in the queue
  typedef struct packed {
    op_e               op;
    logic [FieldW-1:0] key;
    logic [FieldW-1:0] value;
    logic [HomeW-1:0]  home;
  } cmd_t;

endpackage

>>> rtl/htlp_front.sv
// front end: accepts input transfers and classifies the command code
// depends on htlp_pkg
`timescale 1ns / 1ps

module htlp_front (
  input  logic              push,
  input  htlp_pkg::in_item_t in_item_i,
  output logic              full,
  input  logic              q_full_i,
  input  logic              clearing_i,
  output logic              q_push_o,
  output htlp_pkg::cmd_t    cmd_o
);

  // hold off input while the queue is full or the table is being cleared
  assign full     = q_full_i | clearing_i;
  assign q_push_o = push & ~full;

  // map the command code onto an operation
  always_comb begin
    cmd_o.key   = in_item_i.key;
    cmd_o.value = in_item_i.value;
    cmd_o.home  = in_item_i.home_slot;
    case (in_item_i.func)
      htlp_pkg::FuncInsert: cmd_o.op = htlp_pkg::OP_INSERT;
      htlp_pkg::FuncLookup: cmd_o.op = htlp_pkg::OP_LOOKUP;
      htlp_pkg::FuncErase:  cmd_o.op = htlp_pkg::OP_ERASE;
      default:              cmd_o.op = htlp_pkg::OP_NOP;
    endcase
  end

endmodule

>>> rtl/htlp_cmd_queue.sv
// short command queue between the front end and the probe engine
// depends on htlp_pkg
`timescale 1ns / 1ps

module htlp_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  htlp_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output htlp_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  localparam int Depth = htlp_pkg::CmdQueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  htlp_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/htlp_engine.sv
// probe engine: slot memory, linear probe sequencer, entry count, result register
// depends on htlp_pkg
`timescale 1ns / 1ps

module htlp_engine #(
  parameter int TABLE_DEPTH = htlp_pkg::TableDepthDef,
  parameter int KEY_WIDTH   = htlp_pkg::KeyWidthDef,
  parameter int VALUE_WIDTH = htlp_pkg::ValueWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  htlp_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output htlp_pkg::result_t res_o,
  input  logic              res_pop_i
);

  localparam int SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RedW  = (SlotW > htlp_pkg::HomeW) ? SlotW : htlp_pkg::HomeW;
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int WordW = 2 + KEY_WIDTH + VALUE_WIDTH;
  localparam int UsedBit = WordW - 1;
  localparam int DelBit  = WordW - 2;
  localparam int KeyLsb  = VALUE_WIDTH;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_DEPTH - 1);
  localparam logic [RedW:0]    DepthRed = (RedW + 1)'(TABLE_DEPTH);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(TABLE_DEPTH);

  htlp_pkg::eng_state_e state_q, state_d;
  htlp_pkg::op_e        op_q, op_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [RedW-1:0]        slot_q, slot_d;
  logic [SlotW-1:0]       stop_q, stop_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  htlp_pkg::result_t      out_q, out_d;

  // slot memory: {used, deleted, key, value}
  logic [WordW-1:0] mem_q [TABLE_DEPTH];
  logic [WordW-1:0] rd_data_q;
  logic             rd_en, wr_en;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic [WordW-1:0] wr_data;

  logic                   out_free, res_load, last, go;
  logic [SlotW-1:0]       slot_cur, slot_next;
  logic                   rd_used, rd_del, key_eq;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  assign slot_cur  = slot_q[SlotW-1:0];
  assign slot_next = (slot_cur == LastSlot) ? '0 : slot_cur + 1'b1;
  assign last      = (slot_next == stop_q);
  assign out_free  = ~out_valid_q | res_pop_i;
  assign rd_used   = rd_data_q[UsedBit];
  assign rd_del    = rd_data_q[DelBit];
  assign rd_key    = rd_data_q[KeyLsb +: KEY_WIDTH];
  assign rd_val    = rd_data_q[VALUE_WIDTH-1:0];
  assign key_eq    = (rd_key == key_q);
  assign go = ((op_q == htlp_pkg::OP_INSERT) && (count_q != DepthCnt)) ||
              (((op_q == htlp_pkg::OP_LOOKUP) || (op_q == htlp_pkg::OP_ERASE)) &&
               (count_q != '0));

  assign clearing_o  = (state_q == htlp_pkg::ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // sequencer: clearing pass, command pickup, home reduction, probing
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    val_d     = val_q;
    slot_d    = slot_q;
    stop_d    = stop_q;
    count_d   = count_q;
    out_d     = out_q;
    res_load  = 1'b0;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = slot_cur;
    wr_en     = 1'b0;
    wr_addr   = slot_cur;
    wr_data   = '0;
    case (state_q)
      htlp_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (slot_cur == LastSlot) begin
          slot_d  = '0;
          state_d = htlp_pkg::ST_IDLE;
        end else begin
          slot_d = RedW'(slot_next);
        end
      end
      htlp_pkg::ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          key_d     = KEY_WIDTH'(cmd_i.key);
          val_d     = VALUE_WIDTH'(cmd_i.value);
          slot_d    = RedW'(cmd_i.home);
          state_d   = htlp_pkg::ST_REDUCE;
        end
      end
      htlp_pkg::ST_REDUCE: begin
        if ({1'b0, slot_q} >= DepthRed) begin
          // home slot beyond the table: subtract the depth once per cycle
          slot_d = slot_q - DepthRed[RedW-1:0];
        end else begin
          stop_d = (slot_cur == '0) ? LastSlot : slot_cur - 1'b1;
          if (go) begin
            rd_en   = 1'b1;
            state_d = htlp_pkg::ST_PROBE;
          end else begin
            out_d    = '0;
            res_load = 1'b1;
            state_d  = htlp_pkg::ST_IDLE;
          end
        end
      end
      htlp_pkg::ST_PROBE: begin
        // read ahead the following slot while the current one is examined
        rd_en   = 1'b1;
        rd_addr = slot_next;
        slot_d  = RedW'(slot_next);
        out_d   = '0;
        case (op_q)
          htlp_pkg::OP_INSERT: begin
            if (!rd_used) begin
              wr_en    = 1'b1;
              wr_data  = {1'b1, 1'b0, key_q, val_q};
              count_d  = count_q + 1'b1;
              out_d.ok = 1'b1;
              res_load = 1'b1;
            end else if (key_eq || last) begin
              res_load = 1'b1;
            end
          end
          htlp_pkg::OP_LOOKUP, htlp_pkg::OP_ERASE: begin
            if (!rd_used && !rd_del) begin
              res_load = 1'b1;
            end else if (rd_used && key_eq) begin
              out_d.ok          = 1'b1;
              out_d.found_value = htlp_pkg::FieldW'(rd_val);
              res_load          = 1'b1;
              if (op_q == htlp_pkg::OP_ERASE) begin
                // leave a tombstone
                wr_en   = 1'b1;
                wr_data = {1'b0, 1'b1, rd_key, rd_val};
                count_d = count_q - 1'b1;
              end
            end else if (last) begin
              res_load = 1'b1;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
        if (res_load) begin
          state_d = htlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = htlp_pkg::ST_IDLE;
      end
    endcase
  end

  // result register: loaded at the end of a command, freed by a transfer
  always_comb begin
    out_valid_d = out_valid_q & ~res_pop_i;
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htlp_pkg::ST_CLEAR;
      slot_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= htlp_pkg::OP_NOP;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
    end
  end

  // command payload and result payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    stop_q <= stop_d;
    out_q  <= out_d;
  end

  // slot memory with one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // a finished command never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || res_pop_i))
    else $error("result register overwritten");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count beyond table depth");

  // the slot before home is never examined
  a_stop_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == htlp_pkg::ST_PROBE) |-> (slot_cur != stop_q))
    else $error("probe reached the stop slot");

  // a probe write only happens on the cycle that finishes the command
  a_write_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == htlp_pkg::ST_PROBE) |-> res_load)
    else $error("table written without finishing");

  // the entry count moves only together with a table write
  a_count_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(wr_en))
    else $error("entry count changed without a write");

endmodule

>>> rtl/hash_table_linear_probe.sv
// top level: front end, command queue and probe engine; depends on htlp_pkg
// a command is read from the queue, its home reduced below the depth, then k slots probed one per cycle
//   (0 when rejected before probing, else 1 to depth-1); the home reduction is skipped below depth
// the probe engine takes one command at a time and the next only once the last has finished; a 2-entry queue
//   and the result register let input and output stall on their own
// reset: a clearing pass over all TABLE_DEPTH slots marks every slot free; full stays high meanwhile
`timescale 1ns / 1ps

module hash_table_linear_probe #(
  parameter int TABLE_DEPTH = htlp_pkg::TableDepthDef,
  parameter int KEY_WIDTH   = htlp_pkg::KeyWidthDef,
  parameter int VALUE_WIDTH = htlp_pkg::ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  htlp_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output htlp_pkg::result_t  result_o
);

  logic           q_full, q_push, q_valid, q_pop, clearing, res_valid;
  htlp_pkg::cmd_t cmd_in, cmd_out;

  // accept and classify
  htlp_front u_front (
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .q_push_o   (q_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue
  htlp_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out),
    .pop_i   (q_pop)
  );

  // probe and update the table
  htlp_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid),
    .res_o       (result_o),
    .res_pop_i   (pop)
  );

  assign empty = ~res_valid;

endmodule

>>> dv/tb_hash_table_linear_probe.sv
// self-checking testbench for the linear-probing hash table: mirrors the slot table,
// drives insert, lookup, erase and unknown commands with random idling on both queue sides
// depends on htlp_pkg and hash_table_linear_probe
`timescale 1ns / 1ps

module tb_hash_table_linear_probe;

  localparam int TableDepth  = htlp_pkg::TableDepthDef;
  localparam int CycleLimit  = 1_500_000;
  localparam int DrainCycles = TableDepth + 64;
  localparam int PoolSize    = 40;
  localparam int RandomItems = 1100;
  localparam int MaxGap      = 18;

  // code outside the command set, must leave the table untouched
  localparam logic [1:0] FuncUnknown = 2'd3;

  // mirror of the slot table and the queue of results still owed by the block
  class table_mirror;
    logic [htlp_pkg::FieldW-1:0] slot_key [TableDepth];
    logic [htlp_pkg::FieldW-1:0] slot_val [TableDepth];
    bit                          slot_used [TableDepth];
    bit                          slot_tomb [TableDepth];
    int unsigned                 entries;
    htlp_pkg::result_t           pending_results [$];
    int                          errors;

    function new();
      for (int s = 0; s < TableDepth; s++) begin
        slot_key[s]  = '0;
        slot_val[s]  = '0;
        slot_used[s] = 1'b0;
        slot_tomb[s] = 1'b0;
      end
      entries = 0;
      errors  = 0;
    endfunction

    // walk the probe chain for one command and apply its effect
    function htlp_pkg::result_t probe_outcome(htlp_pkg::in_item_t cmd);
      int unsigned       home;
      int unsigned       stop;
      int unsigned       s;
      bit                dup;
      htlp_pkg::result_t res;
      res  = '0;
      dup  = 1'b0;
      home = cmd.home_slot % TableDepth;
      // the slot just before home is never visited
      stop = (home + TableDepth - 1) % TableDepth;
      s    = home;
      case (cmd.func)
        htlp_pkg::FuncInsert: begin
          if (entries + 1 <= TableDepth) begin
            while (s != stop) begin
              if (!slot_used[s]) break;
              if (slot_key[s] == cmd.key) begin
                dup = 1'b1;
                break;
              end
              s = (s + 1) % TableDepth;
            end
            if (!dup && s != stop) begin
              slot_key[s]  = cmd.key;
              slot_val[s]  = cmd.value;
              slot_used[s] = 1'b1;
              slot_tomb[s] = 1'b0;
              entries++;
              res.ok = 1'b1;
            end
          end
        end
        htlp_pkg::FuncLookup, htlp_pkg::FuncErase: begin
          if (entries != 0) begin
            while (s != stop) begin
              // never-used slot ends the chain, tombstones are skipped
              if (!slot_used[s] && !slot_tomb[s]) break;
              if (slot_used[s] && slot_key[s] == cmd.key) begin
                res.ok          = 1'b1;
                res.found_value = slot_val[s];
                if (cmd.func == htlp_pkg::FuncErase) begin
                  slot_used[s] = 1'b0;
                  slot_tomb[s] = 1'b1;
                  entries--;
                end
                break;
              end
              s = (s + 1) % TableDepth;
            end
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_command(htlp_pkg::in_item_t cmd);
      pending_results.push_back(probe_outcome(cmd));
    endfunction

    task report_mismatch(string what, logic [htlp_pkg::FieldW-1:0] got,
                         logic [htlp_pkg::FieldW-1:0] want);
      errors++;
      $display("mismatch %0d at %0t: %s got %h want %h", errors, $realtime, what, got, want);
    endtask

    task check_result(htlp_pkg::result_t got);
      htlp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command pending", got.found_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          report_mismatch("ok", htlp_pkg::FieldW'(got.ok), htlp_pkg::FieldW'(want.ok));
        end
        if (got.found_value !== want.found_value) begin
          report_mismatch("found_value", got.found_value, want.found_value);
        end
      end
    endtask
  endclass

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               push    = 1'b0;
  logic               pop     = 1'b0;
  htlp_pkg::in_item_t in_item = '0;
  logic               full;
  logic               empty;
  htlp_pkg::result_t  result_o;

  table_mirror mirror = new();
  int          in_gap_max  = MaxGap;
  int          out_gap_max = MaxGap;

  hash_table_linear_probe u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_item_i(in_item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one command transfer after a random idle stretch
  task automatic send_cmd(logic [1:0] func, logic [htlp_pkg::FieldW-1:0] key,
                          logic [htlp_pkg::FieldW-1:0] value,
                          logic [htlp_pkg::HomeW-1:0] home);
    int                 gap;
    htlp_pkg::in_item_t cmd;
    cmd.func      = func;
    cmd.key       = key;
    cmd.value     = value;
    cmd.home_slot = home;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= cmd;
    do @(posedge clk_i); while (full);
    mirror.note_command(cmd);
  endtask

  // result side: random stalls, every transfer checked against the mirror
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) begin
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MaxGap;
      end
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      mirror.check_result(result_o);
      taken++;
    end
  end

  // cycle limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    logic [htlp_pkg::FieldW-1:0] pool_key [PoolSize];
    logic [htlp_pkg::HomeW-1:0]  pool_home [PoolSize];
    logic [htlp_pkg::FieldW-1:0] last_key;
    int                          pick;
    int                          roll;
    int                          spare;

    for (int i = 0; i < PoolSize; i++) begin
      pool_key[i]  = $urandom;
      // crowd the homes around the wrap point so chains cross it
      pool_home[i] = htlp_pkg::HomeW'(TableDepth - 8 + $urandom_range(0, 15));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, field extremes, wrap, duplicates and tombstones
    send_cmd(htlp_pkg::FuncLookup, 32'h0000_0000, 32'h0000_0000, 8'd0);
    send_cmd(htlp_pkg::FuncErase,  32'hffff_ffff, 32'hffff_ffff, 8'd255);
    send_cmd(FuncUnknown,          32'hffff_ffff, 32'hffff_ffff, 8'd255);
    send_cmd(htlp_pkg::FuncInsert, 32'h0000_0000, 32'hffff_ffff, 8'd255);
    send_cmd(htlp_pkg::FuncInsert, 32'hffff_ffff, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncInsert, 32'h0000_0000, 32'h0000_0001, 8'd255);
    send_cmd(htlp_pkg::FuncLookup, 32'hffff_ffff, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncLookup, 32'h0000_0000, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncErase,  32'h0000_0000, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncLookup, 32'hffff_ffff, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncLookup, 32'h0000_0000, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncInsert, 32'h1234_5678, 32'ha5a5_a5a5, 8'd255);
    send_cmd(FuncUnknown,          32'hffff_ffff, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncLookup, 32'hffff_ffff, 32'h0000_0000, 8'd255);
    send_cmd(htlp_pkg::FuncErase,  32'hffff_ffff, 32'h0000_0000, 8'd0);
    send_cmd(htlp_pkg::FuncErase,  32'hffff_ffff, 32'h0000_0000, 8'd0);
    send_cmd(htlp_pkg::FuncInsert, 32'h8000_0000, 32'h7fff_ffff, 8'd128);
    send_cmd(htlp_pkg::FuncLookup, 32'h8000_0000, 32'h0000_0000, 8'd128);
    send_cmd(htlp_pkg::FuncLookup, 32'h8000_0000, 32'h0000_0000, 8'd127);
    // a key behind a tombstone is stored a second time in the tombstone
    send_cmd(htlp_pkg::FuncInsert, 32'h0000_00aa, 32'h1111_1111, 8'd10);
    send_cmd(htlp_pkg::FuncInsert, 32'h0000_00bb, 32'h2222_2222, 8'd10);
    send_cmd(htlp_pkg::FuncErase,  32'h0000_00aa, 32'h0000_0000, 8'd10);
    send_cmd(htlp_pkg::FuncInsert, 32'h0000_00bb, 32'h3333_3333, 8'd10);
    send_cmd(htlp_pkg::FuncLookup, 32'h0000_00bb, 32'h0000_0000, 8'd10);

    // random: mostly pool keys on their own homes, some noise
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) begin
        in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MaxGap;
      end
      pick = $urandom_range(0, PoolSize - 1);
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_cmd(htlp_pkg::FuncInsert, pool_key[pick], $urandom, pool_home[pick]);
      end else if (roll < 72) begin
        send_cmd(htlp_pkg::FuncLookup, pool_key[pick], $urandom, pool_home[pick]);
      end else if (roll < 90) begin
        send_cmd(htlp_pkg::FuncErase, pool_key[pick], $urandom, pool_home[pick]);
      end else if (roll < 95) begin
        send_cmd(2'($urandom_range(0, 2)), $urandom, $urandom, htlp_pkg::HomeW'($urandom));
      end else begin
        send_cmd(FuncUnknown, $urandom, $urandom, htlp_pkg::HomeW'($urandom));
      end
    end

    // fill every slot but one, then exercise the full and no-free-slot cases
    spare = $urandom_range(0, TableDepth - 1);
    while (mirror.slot_used[spare]) spare = (spare + 1) % TableDepth;
    for (int s = 0; s < TableDepth; s++) begin
      if (s != spare && !mirror.slot_used[s]) begin
        send_cmd(htlp_pkg::FuncInsert, $urandom, $urandom, htlp_pkg::HomeW'(s));
      end
    end
    last_key = $urandom;
    // only free slot sits just before home
    send_cmd(htlp_pkg::FuncInsert, last_key, $urandom, htlp_pkg::HomeW'(spare + 1));
    send_cmd(htlp_pkg::FuncInsert, last_key, $urandom, htlp_pkg::HomeW'(spare));
    // table full
    send_cmd(htlp_pkg::FuncInsert, $urandom, $urandom, htlp_pkg::HomeW'($urandom));
    // key on the skipped slot, then a miss over the whole range
    send_cmd(htlp_pkg::FuncLookup, last_key, $urandom, htlp_pkg::HomeW'(spare + 1));
    send_cmd(htlp_pkg::FuncLookup, $urandom, $urandom, htlp_pkg::HomeW'($urandom));
    send_cmd(htlp_pkg::FuncLookup, last_key, $urandom, htlp_pkg::HomeW'(spare));
    send_cmd(htlp_pkg::FuncErase, last_key, $urandom, htlp_pkg::HomeW'(spare));
    send_cmd(htlp_pkg::FuncInsert, $urandom, $urandom, htlp_pkg::HomeW'(spare + 1));
    push <= 1'b0;

    // drain
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
